FILE: hdl/gpuo_pkg.sv
// shared types, widths and helpers for the gf(2) polynomial unit order block
package gpuo_pkg;

   localparam int DEG_MAX_DEF = 16;
   localparam int PW          = 17;
   localparam int RW          = 16;
   localparam int DW          = 5;
   localparam int EW          = 17;
   localparam int OW          = 16;
   localparam int TIW         = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOT_UNIT = 2'd1,
      STAT_BAD_MOD  = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic red_step;
      logic gcd_init;
      logic gcd_step;
      logic tab_init;
      logic tab_step;
      logic pow_init;
      logic pow_step;
   } cmd_type;

   typedef struct packed {
      logic deg_bad;
      logic red_last;
      logic rem_zero;
      logic gcd_done;
      logic gcd_one;
      logic tab_last;
      logic pow_done;
   } stat_type;

   // degree of a nonzero polynomial, zero for the zero polynomial
   function automatic logic [DW-1:0] poly_deg(input logic [PW-1:0] p);
      logic [DW-1:0] d;
      d = '0;
      for (int i = 0; i < PW; i++) begin
         if (p[i]) begin
            d = DW'(i);
         end
      end
      return d;
   endfunction

endpackage

FILE: hdl/gpuo_dpath.sv
// datapath: reduction, gcd, power table and order counter
module gpuo_dpath #(
   parameter int DEG_MAX = gpuo_pkg::DEG_MAX_DEF
) (
   input  logic                        clock,
   input  logic [gpuo_pkg::PW-1:0]     modulus,
   input  logic [gpuo_pkg::PW-1:0]     residue,
   input  gpuo_pkg::cmd_type           cmd,
   output gpuo_pkg::stat_type          stat,
   output logic [gpuo_pkg::OW-1:0]     order
);
   import gpuo_pkg::*;

   localparam logic [DW:0] DEG_LIM = (DW + 1)'(DEG_MAX);

   logic [PW-1:0]  mod_ff, mod_in;
   logic [DW-1:0]  deg_ff, deg_in;
   logic [PW-1:0]  res_ff, res_in;
   logic [PW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  cnt_ff, cnt_in;
   logic [PW-1:0]  ga_ff, ga_in;
   logic [PW-1:0]  gb_ff, gb_in;
   logic [PW-1:0]  t_ff, t_in;
   logic [TIW-1:0] tix_ff, tix_in;
   logic [RW-1:0]  tab_ff [RW];
   logic [RW-1:0]  p_ff, p_in;
   logic [EW-1:0]  e_ff, e_in;
   logic [PW-1:0]  rem_sh, t_sh;
   logic [DW-1:0]  da, db;
   logic [RW-1:0]  prod;
   logic [EW-1:0]  limit;

   always_comb begin
      mod_in = mod_ff;
      deg_in = deg_ff;
      res_in = res_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      ga_in  = ga_ff;
      gb_in  = gb_ff;
      t_in   = t_ff;
      tix_in = tix_ff;
      p_in   = p_ff;
      e_in   = e_ff;
      da     = poly_deg(ga_ff);
      db     = poly_deg(gb_ff);
      rem_sh = {rem_ff[PW-2:0], res_ff[PW-1]};
      t_sh   = {t_ff[PW-2:0], 1'b0};
      prod   = '0;
      for (int i = 0; i < RW; i++) begin
         if (p_ff[i]) begin
            prod = prod ^ tab_ff[i];
         end
      end

      if (cmd.load) begin
         mod_in = modulus;
         deg_in = poly_deg(modulus);
         res_in = residue;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.red_step) begin
         rem_in = rem_sh[deg_ff] ? (rem_sh ^ mod_ff) : rem_sh;
         res_in = {res_ff[PW-2:0], 1'b0};
         cnt_in = cnt_ff + DW'(1);
      end
      if (cmd.gcd_init) begin
         ga_in = mod_ff;
         gb_in = rem_ff;
      end
      if (cmd.gcd_step) begin
         if (da >= db) begin
            ga_in = ga_ff ^ (gb_ff << (da - db));
         end else begin
            gb_in = gb_ff ^ (ga_ff << (db - da));
         end
      end
      if (cmd.tab_init) begin
         t_in   = rem_ff;
         tix_in = '0;
      end
      if (cmd.tab_step) begin
         t_in   = t_sh[deg_ff] ? (t_sh ^ mod_ff) : t_sh;
         tix_in = tix_ff + TIW'(1);
      end
      if (cmd.pow_init) begin
         p_in = rem_ff[RW-1:0];
         e_in = EW'(1);
      end
      if (cmd.pow_step) begin
         p_in = prod;
         e_in = e_ff + EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      mod_ff <= mod_in;
      deg_ff <= deg_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      ga_ff  <= ga_in;
      gb_ff  <= gb_in;
      t_ff   <= t_in;
      tix_ff <= tix_in;
      p_ff   <= p_in;
      e_ff   <= e_in;
      if (cmd.tab_step) begin
         tab_ff[tix_ff] <= t_ff[RW-1:0];
      end
   end

   assign limit = EW'(1) << deg_ff;

   always_comb begin
      stat.deg_bad  = (mod_ff[PW-1:1] == '0) || ({1'b0, deg_ff} > DEG_LIM);
      stat.red_last = (cnt_ff == DW'(PW - 1));
      stat.rem_zero = (rem_ff == '0);
      stat.gcd_done = (ga_ff == '0) || (gb_ff == '0);
      stat.gcd_one  = ((ga_ff | gb_ff) == PW'(1));
      stat.tab_last = (tix_ff == TIW'(RW - 1));
      stat.pow_done = (p_ff == RW'(1)) || (e_ff == limit);
   end

   assign order = e_ff[OW-1:0];

endmodule

FILE: hdl/gpuo_ctrl.sv
// controller state machine sequencing the datapath phases
module gpuo_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gpuo_pkg::stat_type     stat,
   output gpuo_pkg::cmd_type      cmd,
   input  logic                   out_free,
   output logic                   out_load,
   output gpuo_pkg::status_type   out_status
);
   import gpuo_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_REDUCE = 8'b0000_0100,
      ST_GINIT  = 8'b0000_1000,
      ST_GCD    = 8'b0001_0000,
      ST_TABLE  = 8'b0010_0000,
      ST_POWER  = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.deg_bad) begin
               code_in  = STAT_BAD_MOD;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.red_step = 1'b1;
            if (stat.red_last) begin
               state_in = ST_GINIT;
            end
         end
         ST_GINIT: begin
            cmd.gcd_init = 1'b1;
            cmd.tab_init = 1'b1;
            cmd.pow_init = 1'b1;
            if (stat.rem_zero) begin
               code_in  = STAT_NOT_UNIT;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (stat.gcd_done) begin
               if (stat.gcd_one) begin
                  state_in = ST_TABLE;
               end else begin
                  code_in  = STAT_NOT_UNIT;
                  state_in = ST_FINISH;
               end
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_TABLE: begin
            cmd.tab_step = 1'b1;
            if (stat.tab_last) begin
               state_in = ST_POWER;
            end
         end
         ST_POWER: begin
            if (stat.pow_done) begin
               code_in  = STAT_OK;
               state_in = ST_FINISH;
            end else begin
               cmd.pow_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= STAT_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign out_status = code_ff;

endmodule

FILE: hdl/gf2_poly_unit_order.sv
// top level: multiplicative order of a gf(2) polynomial residue modulo a polynomial
// sequence: a 17-step reduction, a gcd loop and a 16-step power table, then one power
// step per multiply until the residue power reaches one or the exponent reaches 2^deg;
// a bad modulus finishes after the check, a non-unit residue after gcd init or the gcd loop
// one item at a time; the power loop does one table-driven modular multiply per cycle
// synchronous active-high reset clears the controller and the result valid flag
module gf2_poly_unit_order #(
   parameter int DEG_MAX = gpuo_pkg::DEG_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gpuo_pkg::REQ_TDATA_W-1:0]    req_tdata,  // modulus, residue, zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gpuo_pkg::RSP_TDATA_W-1:0]    rsp_tdata   // order, status, zero pad
);
   import gpuo_pkg::*;

   cmd_type          cmd;
   stat_type         stat;
   logic             out_free;
   logic             out_load;
   status_type       out_status;
   logic [OW-1:0]    dp_order;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [OW-1:0]    rsp_order_ff, rsp_order_in;
   status_type       rsp_status_ff, rsp_status_in;

   gpuo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .stat       (stat),
      .cmd        (cmd),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_status (out_status)
   );

   gpuo_dpath #(
      .DEG_MAX (DEG_MAX)
   ) u_dpath (
      .clock   (clock),
      .modulus (req_tdata[PW-1:0]),
      .residue (req_tdata[2*PW-1:PW]),
      .cmd     (cmd),
      .stat    (stat),
      .order   (dp_order)
   );

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_order_in  = rsp_order_ff;
      rsp_status_in = rsp_status_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_order_in  = (out_status == STAT_OK) ? dp_order : '0;
         rsp_status_in = out_status;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_order_ff  <= rsp_order_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - OW - 2)'(0), rsp_status_ff, rsp_order_ff};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while busy");

   a_fail_order_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status_ff != STAT_OK) |-> (rsp_order_ff == '0))
      else $error("nonzero order with failing status");

   a_ok_order_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status_ff == STAT_OK) |-> (rsp_order_ff != '0))
      else $error("zero order with ok status");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (out_status == STAT_OK || out_status == STAT_NOT_UNIT
                    || out_status == STAT_BAD_MOD))
      else $error("undefined status code");

endmodule
